// File: src/cget_pkg.sv
// cget_pkg: shared constants, types and helpers of the cross gradient edge threshold unit
// depends on nothing; imported by cget_line_store, cross_gradient_edge_threshold_unit and its testbench
package cget_pkg;

    // pixel and field widths
    localparam int PIXEL_BITS = 8;
    localparam int THR_BITS   = 9;
    localparam int LW_BITS    = 11;
    localparam int FH_BITS    = 13;
    localparam int ROW_BITS   = 12;
    localparam int GRAD_BITS  = 9;

    // configuration port
    localparam int ADDR_BITS  = 4;
    localparam int DATA_BITS  = 32;
    localparam int IDX_BITS   = 2;

    typedef logic [IDX_BITS-1:0]   t_reg_idx;
    typedef logic [PIXEL_BITS-1:0] t_pixel;

    localparam t_reg_idx REG_THRESHOLD    = 2'd0;
    localparam t_reg_idx REG_LINE_WIDTH   = 2'd1;
    localparam t_reg_idx REG_FRAME_HEIGHT = 2'd2;

    // register reset values
    localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 9'd50;
    localparam logic [LW_BITS-1:0]  WIDTH_RESET     = 11'd12;
    localparam logic [FH_BITS-1:0]  HEIGHT_RESET    = 13'd12;

    // frame limits
    localparam logic [FH_BITS-1:0]  MIN_SIZE   = 13'd3;
    localparam logic [FH_BITS-1:0]  MAX_HEIGHT = 13'd4096;

    // absolute difference of two pixels
    function automatic t_pixel abs_diff(input t_pixel a, input t_pixel b);
        t_pixel d;
        if (a > b) begin
            d = a - b;
        end else begin
            d = b - a;
        end
        return d;
    endfunction

endpackage

// File: src/cget_line_store.sv
// cget_line_store: the two line memories (row above, two rows above) with registered reads
// depends on cget_pkg; a write and a read of the same column in one cycle forwards the new data
module cget_line_store #(
    parameter int DEPTH     = 1024,
    parameter int ADDR_BITS = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rd_en,
    input  logic [ADDR_BITS-1:0]      i_rd_addr,
    input  logic                      i_wr_en,
    input  logic [ADDR_BITS-1:0]      i_wr_addr,
    input  cget_pkg::t_pixel          i_wr_above,
    input  cget_pkg::t_pixel          i_wr_two_above,
    output cget_pkg::t_pixel          o_above,
    output cget_pkg::t_pixel          o_two_above
);
    import cget_pkg::*;

    t_pixel mem_above     [DEPTH];
    t_pixel mem_two_above [DEPTH];

    t_pixel r_rd_above;
    t_pixel r_rd_two_above;
    logic   r_fwd;
    t_pixel r_fwd_above;
    t_pixel r_fwd_two_above;

    // row above memory
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_above[i_wr_addr] <= i_wr_above;
        end
        if (i_rd_en) begin
            r_rd_above <= mem_above[i_rd_addr];
        end
    end

    // two rows above memory
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_two_above[i_wr_addr] <= i_wr_two_above;
        end
        if (i_rd_en) begin
            r_rd_two_above <= mem_two_above[i_rd_addr];
        end
    end

    // bypass for a read that collides with the write of the same cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd           <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_above     <= i_wr_above;
            r_fwd_two_above <= i_wr_two_above;
        end
    end

    assign o_above     = r_fwd ? r_fwd_above     : r_rd_above;
    assign o_two_above = r_fwd ? r_fwd_two_above : r_rd_two_above;

endmodule

// File: src/cross_gradient_edge_threshold_unit.sv
// cross_gradient_edge_threshold_unit: top level, counters, gradient stage, result queue, registers
// depends on cget_pkg and cget_line_store
// a result passes the gradient stage register and then the result queue before it is presented
// throughput: one pixel per clock when not stalled; line memories are read ahead of the gradient
// a three-entry result queue decouples the output side; input stalls only when it may fill
// reset (synchronous, active low) clears counters, delay taps, queue and registers to defaults
// line memories are not cleared; their contents are valid once a full row has been written
module cross_gradient_edge_threshold_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // pixel channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [cget_pkg::PIXEL_BITS-1:0]     i_pixel,
    input  logic                                i_frame_start,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_edge_flag,
    output logic [cget_pkg::GRAD_BITS-1:0]      o_gradient,
    output logic [cget_pkg::ROW_BITS-1:0]       o_centre_row,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_centre_col,
    output logic                                o_frame_last,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cget_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [cget_pkg::DATA_BITS-1:0]      pwdata,
    output logic [cget_pkg::DATA_BITS-1:0]      prdata,
    output logic                                pready
);
    import cget_pkg::*;

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam logic [FH_BITS-1:0] MAX_W = FH_BITS'(MAX_WIDTH);
    localparam int QDEPTH = 3;
    localparam int QPTR_BITS = 2;
    localparam logic [QPTR_BITS-1:0] QLAST = QPTR_BITS'(QDEPTH - 1);
    localparam logic [QPTR_BITS:0] QFULL = (QPTR_BITS + 1)'(QDEPTH);

    typedef struct packed {
        logic                  edge_flag;
        logic [GRAD_BITS-1:0]  gradient;
        logic [ROW_BITS-1:0]   centre_row;
        logic [COL_BITS-1:0]   centre_col;
        logic                  frame_last;
    } t_result;

    // configuration registers
    logic [THR_BITS-1:0] r_thr;
    logic [LW_BITS-1:0]  r_line_width;
    logic [FH_BITS-1:0]  r_frame_height;

    // position counters
    logic [COL_BITS-1:0] r_col;
    logic [ROW_BITS-1:0] r_row;

    // gradient stage
    logic                r_s1_valid;
    t_pixel              r_s1_pixel;
    logic                r_s1_res;
    logic                r_s1_last;
    logic [ROW_BITS-1:0] r_s1_row;
    logic [COL_BITS-1:0] r_s1_col;
    logic [COL_BITS-1:0] r_s1_addr;

    // neighbourhood taps
    t_pixel r_ad0;
    t_pixel r_ad1;
    t_pixel r_two_above;
    t_pixel r_prev;

    // result queue
    t_result              r_q [QDEPTH];
    logic [QPTR_BITS-1:0] r_head;
    logic [QPTR_BITS-1:0] r_tail;
    logic [QPTR_BITS-1:0] r_cnt;

    logic                w_acc;
    logic                w_cfg_wr;
    t_reg_idx            w_idx;
    logic [FH_BITS-1:0]  w_width_ext;
    logic [FH_BITS-1:0]  w_width;
    logic [FH_BITS-1:0]  w_height;
    logic [COL_BITS-1:0] w_col_last;
    logic [ROW_BITS-1:0] w_row_last;
    logic [COL_BITS-1:0] w_col_cur;
    logic [ROW_BITS-1:0] w_row_cur;
    logic                w_col_end;
    logic                w_row_end;
    t_pixel              w_east;
    t_pixel              w_far;
    logic [GRAD_BITS-1:0] w_grad;
    t_result             w_res;
    logic                w_push;
    logic                w_pop;

    assign w_acc = i_in_valid && !o_in_stall;

    // register access
    assign pready   = 1'b1;
    assign w_idx    = paddr[ADDR_BITS-1:2];
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr          <= THRESHOLD_RESET;
            r_line_width   <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (w_cfg_wr) begin
            case (w_idx)
                REG_THRESHOLD:    r_thr          <= pwdata[THR_BITS-1:0];
                REG_LINE_WIDTH:   r_line_width   <= pwdata[LW_BITS-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[FH_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_THRESHOLD:    prdata = DATA_BITS'(r_thr);
            REG_LINE_WIDTH:   prdata = DATA_BITS'(r_line_width);
            REG_FRAME_HEIGHT: prdata = DATA_BITS'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    // frame size in use, saturated to the legal range
    assign w_width_ext = FH_BITS'(r_line_width);

    always_comb begin
        if (w_width_ext < MIN_SIZE) begin
            w_width = MIN_SIZE;
        end else if (w_width_ext > MAX_W) begin
            w_width = MAX_W;
        end else begin
            w_width = w_width_ext;
        end
        if (r_frame_height < MIN_SIZE) begin
            w_height = MIN_SIZE;
        end else if (r_frame_height > MAX_HEIGHT) begin
            w_height = MAX_HEIGHT;
        end else begin
            w_height = r_frame_height;
        end
    end

    assign w_col_last = COL_BITS'(w_width - 13'd1);
    assign w_row_last = ROW_BITS'(w_height - 13'd1);

    // position of the incoming pixel: frame start restarts, stale counters saturate
    always_comb begin
        if (i_frame_start) begin
            w_col_cur = '0;
            w_row_cur = '0;
        end else begin
            w_col_cur = (r_col > w_col_last) ? w_col_last : r_col;
            w_row_cur = (r_row > w_row_last) ? w_row_last : r_row;
        end
    end

    assign w_col_end = (w_col_cur == w_col_last);
    assign w_row_end = (w_row_cur == w_row_last);

    // raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_acc) begin
            if (w_col_end) begin
                r_col <= '0;
                r_row <= w_row_end ? '0 : w_row_cur + 1'b1;
            end else begin
                r_col <= w_col_cur + 1'b1;
                r_row <= w_row_cur;
            end
        end
    end

    // gradient stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_acc;
        end
    end

    // gradient stage payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_pixel <= i_pixel;
            r_s1_res   <= (w_row_cur >= ROW_BITS'(2)) && (w_col_cur >= COL_BITS'(2));
            r_s1_last  <= w_row_end && w_col_end;
            r_s1_row   <= w_row_cur - 1'b1;
            r_s1_col   <= w_col_cur - 1'b1;
            r_s1_addr  <= w_col_cur;
        end
    end

    // line memories, read at accept and written in the gradient stage
    cget_line_store #(
        .DEPTH     (MAX_WIDTH),
        .ADDR_BITS (COL_BITS)
    ) u_line_store (
        .i_clk          (i_clk),
        .i_rd_en        (w_acc),
        .i_rd_addr      (w_col_cur),
        .i_wr_en        (r_s1_valid),
        .i_wr_addr      (r_s1_addr),
        .i_wr_above     (r_s1_pixel),
        .i_wr_two_above (w_east),
        .o_above        (w_east),
        .o_two_above    (w_far)
    );

    // cross gradient |E-W| + |N-S|, never wraps
    assign w_grad = GRAD_BITS'(abs_diff(w_east, r_ad1)) +
                    GRAD_BITS'(abs_diff(r_two_above, r_prev));

    always_comb begin
        w_res.edge_flag  = (w_grad > r_thr);
        w_res.gradient   = w_grad;
        w_res.centre_row = r_s1_row;
        w_res.centre_col = r_s1_col;
        w_res.frame_last = r_s1_last;
    end

    // neighbourhood taps advance once per pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ad0       <= '0;
            r_ad1       <= '0;
            r_two_above <= '0;
            r_prev      <= '0;
        end else if (r_s1_valid) begin
            r_ad0       <= w_east;
            r_ad1       <= r_ad0;
            r_two_above <= w_far;
            r_prev      <= r_s1_pixel;
        end
    end

    // result queue
    assign w_push = r_s1_valid && r_s1_res;
    assign w_pop  = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_tail <= (r_tail == QLAST) ? '0 : r_tail + 1'b1;
            end
            if (w_pop) begin
                r_head <= (r_head == QLAST) ? '0 : r_head + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_tail] <= w_res;
        end
    end

    // stall while queued plus in-flight results could overrun the queue
    assign o_in_stall = ((QPTR_BITS + 1)'(r_cnt) + (QPTR_BITS + 1)'(r_s1_valid)) >= QFULL;

    assign o_out_valid  = (r_cnt != '0);
    assign o_edge_flag  = r_q[r_head].edge_flag;
    assign o_gradient   = r_q[r_head].gradient;
    assign o_centre_row = r_q[r_head].centre_row;
    assign o_centre_col = r_q[r_head].centre_col;
    assign o_frame_last = r_q[r_head].frame_last;

    // queue never overflows
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |-> (r_cnt != QPTR_BITS'(QDEPTH)))
        else $error("result queue overflow");

    // an accepted pixel reaches the gradient stage next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_s1_valid)
        else $error("accepted pixel lost before gradient stage");

    // input stalls only when the queue holds at least two results
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_cnt >= QPTR_BITS'(2)))
        else $error("input stalled with queue room");

    // only interior centres are reported
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_centre_row != '0) && (o_centre_col != '0)))
        else $error("border centre reported");

endmodule

// File: verif/cross_gradient_edge_threshold_unit_test.sv
// cross_gradient_edge_threshold_unit_test: self-checking testbench of the cross gradient edge unit
// holds a scoreboard class that predicts every judged centre, plus tasks for pixels and registers
// depends on cget_pkg and the cross_gradient_edge_threshold_unit rtl
module cross_gradient_edge_threshold_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cget_pkg::*;

    localparam int LINE_MAX      = 1024;
    localparam int COL_BITS      = $clog2(LINE_MAX);
    localparam int RANDOM_PIXELS = 1350;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 1000000;

    // index with no register behind it
    localparam t_reg_idx REG_UNMAPPED = 2'd3;

    // one judged centre as the block reports it
    typedef struct packed {
        logic                 edge_flag;
        logic [GRAD_BITS-1:0] gradient;
        logic [ROW_BITS-1:0]  centre_row;
        logic [COL_BITS-1:0]  centre_col;
        logic                 frame_last;
    } t_judgement;

    // predictor of the neighbourhood and the judgements it produces
    class edge_scoreboard;
        logic [THR_BITS-1:0] threshold;
        logic [LW_BITS-1:0]  width_reg;
        logic [FH_BITS-1:0]  height_reg;
        t_pixel              above_row [LINE_MAX];
        bit                  above_row_ok [LINE_MAX];
        t_pixel              two_above_row [LINE_MAX];
        bit                  two_above_row_ok [LINE_MAX];
        t_pixel              west_pipe [2];
        bit                  west_pipe_ok [2];
        t_pixel              north_tap;
        bit                  north_ok;
        t_pixel              south_tap;
        int                  col_cnt;
        int                  row_cnt;
        t_judgement          judgements_due [$];
        int                  mismatches;
        int                  checked;

        function new();
            threshold  = THRESHOLD_RESET;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            foreach (above_row[i]) begin
                above_row[i]        = '0;
                above_row_ok[i]     = 1'b0;
                two_above_row[i]    = '0;
                two_above_row_ok[i] = 1'b0;
            end
            west_pipe[0]    = '0;
            west_pipe[1]    = '0;
            west_pipe_ok[0] = 1'b1;
            west_pipe_ok[1] = 1'b1;
            north_tap       = '0;
            north_ok        = 1'b1;
            south_tap       = '0;
            col_cnt         = 0;
            row_cnt         = 0;
            mismatches      = 0;
            checked         = 0;
        endfunction

        function int eff_width();
            if (width_reg < MIN_SIZE) return int'(MIN_SIZE);
            if (width_reg > LINE_MAX) return LINE_MAX;
            return int'(width_reg);
        endfunction

        function int eff_height();
            if (height_reg < MIN_SIZE) return int'(MIN_SIZE);
            if (height_reg > MAX_HEIGHT) return int'(MAX_HEIGHT);
            return int'(height_reg);
        endfunction

        function void set_reg(t_reg_idx idx, logic [DATA_BITS-1:0] value);
            case (idx)
                REG_THRESHOLD:    threshold  = value[THR_BITS-1:0];
                REG_LINE_WIDTH:   width_reg  = value[LW_BITS-1:0];
                REG_FRAME_HEIGHT: height_reg = value[FH_BITS-1:0];
                default: ;
            endcase
        endfunction

        // next pixel without frame start would judge a centre from never written line data
        function bit centre_unwritten();
            int col;
            int row;
            col = (col_cnt > eff_width() - 1) ? eff_width() - 1 : col_cnt;
            row = (row_cnt > eff_height() - 1) ? eff_height() - 1 : row_cnt;
            return row >= 2 && col >= 2 && !(above_row_ok[col] && west_pipe_ok[1] && north_ok);
        endfunction

        // advance the neighbourhood by one accepted pixel transaction
        function void note_pixel(t_pixel pix, bit frame_start);
            int         w;
            int         h;
            int         col;
            int         row;
            int         grad;
            t_pixel     east;
            t_pixel     far_north;
            bit         east_ok;
            bit         far_north_ok;
            t_judgement j;
            w = eff_width();
            h = eff_height();
            if (frame_start) begin
                col_cnt = 0;
                row_cnt = 0;
            end
            // a counter past the new last index acts as the last index
            if (col_cnt > w - 1) col_cnt = w - 1;
            if (row_cnt > h - 1) row_cnt = h - 1;
            col          = col_cnt;
            row          = row_cnt;
            east         = above_row[col];
            east_ok      = above_row_ok[col];
            far_north    = two_above_row[col];
            far_north_ok = two_above_row_ok[col];

            // centre (row-1, col-1) is judged once its whole cross is in place
            if (row >= 2 && col >= 2) begin
                grad = ((east > west_pipe[1]) ? east - west_pipe[1] : west_pipe[1] - east)
                     + ((north_tap > south_tap) ? north_tap - south_tap : south_tap - north_tap);
                j.edge_flag  = (grad > threshold);
                j.gradient   = GRAD_BITS'(grad);
                j.centre_row = ROW_BITS'(row - 1);
                j.centre_col = COL_BITS'(col - 1);
                j.frame_last = (row == h - 1) && (col == w - 1);
                judgements_due.push_back(j);
            end

            // line stores and delay taps
            two_above_row[col]    = east;
            two_above_row_ok[col] = east_ok;
            above_row[col]        = pix;
            above_row_ok[col]     = 1'b1;
            west_pipe[1]          = west_pipe[0];
            west_pipe_ok[1]       = west_pipe_ok[0];
            west_pipe[0]          = east;
            west_pipe_ok[0]       = east_ok;
            north_tap             = far_north;
            north_ok              = far_north_ok;
            south_tap             = pix;

            // raster counters, frames wrap on their own
            if (col >= w - 1) begin
                col_cnt = 0;
                row_cnt = (row >= h - 1) ? 0 : row + 1;
            end else begin
                col_cnt = col + 1;
            end
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                $error("%s: expected %0d, actual %0d", field, want, got);
            end
        endfunction

        // compare one accepted result transaction with the oldest prediction
        function void check_judgement(t_judgement got);
            t_judgement want;
            if (judgements_due.size() == 0) begin
                mismatches++;
                $error("result with nothing expected: row %0d col %0d gradient %0d",
                       got.centre_row, got.centre_col, got.gradient);
                return;
            end
            want = judgements_due.pop_front();
            checked++;
            compare_field("edge_flag", want.edge_flag, got.edge_flag);
            compare_field("gradient", want.gradient, got.gradient);
            compare_field("centre_row", want.centre_row, got.centre_row);
            compare_field("centre_col", want.centre_col, got.centre_col);
            compare_field("frame_last", want.frame_last, got.frame_last);
        endfunction

        function int pending();
            return judgements_due.size();
        endfunction
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_stall;
    t_pixel               i_pixel       = '0;
    logic                 i_frame_start = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall   = 1'b0;
    logic                 o_edge_flag;
    logic [GRAD_BITS-1:0] o_gradient;
    logic [ROW_BITS-1:0]  o_centre_row;
    logic [COL_BITS-1:0]  o_centre_col;
    logic                 o_frame_last;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [ADDR_BITS-1:0] paddr         = '0;
    logic [DATA_BITS-1:0] pwdata        = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    edge_scoreboard judge = new();
    bit             sender_quiet = 1'b0;
    t_pixel         last_pix     = '0;
    int             pixels_sent  = 0;
    int             settings_cnt = 0;
    int             cycles       = 0;
    int             stall_left   = 0;

    cross_gradient_edge_threshold_unit #(
        .MAX_WIDTH(LINE_MAX)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_pixel      (i_pixel),
        .i_frame_start(i_frame_start),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_edge_flag  (o_edge_flag),
        .o_gradient   (o_gradient),
        .o_centre_row (o_centre_row),
        .o_centre_col (o_centre_col),
        .o_frame_last (o_frame_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycles, judge.pending());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // output backpressure: short and long stalls with quiet stretches
    always @(posedge i_clk) begin : out_stall_gen
        int roll;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                i_out_stall <= 1'b0;
                stall_left  <= $urandom_range(50, 200);
            end else if (roll < 55) begin
                i_out_stall <= 1'b0;
                stall_left  <= $urandom_range(0, 3);
            end else if (roll < 93) begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(0, 3);
            end else begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(8, 40);
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            judge.check_judgement({o_edge_flag, o_gradient, o_centre_row, o_centre_col,
                                   o_frame_last});
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (sender_quiet || roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // extremes, near neighbours of the last pixel, or anything
    function automatic t_pixel pick_pixel();
        int roll;
        int v;
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            last_pix = '0;
        end else if (roll < 24) begin
            last_pix = '1;
        end else if (roll < 50) begin
            v = int'(last_pix) + int'($urandom_range(0, 8)) - 4;
            last_pix = t_pixel'((v < 0) ? 0 : (v > 255) ? 255 : v);
        end else begin
            last_pix = t_pixel'($urandom_range(0, 255));
        end
        return last_pix;
    endfunction

    // upper bits beyond the register width now and then
    function automatic logic [DATA_BITS-1:0] with_junk(int unsigned value, int bits);
        if ($urandom_range(0, 3) == 0) return value | ($urandom << bits);
        return value;
    endfunction

    // one pixel transaction, waits until accepted
    task automatic send_pixel(t_pixel pix, bit frame_start);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pixel       <= pix;
        i_frame_start <= frame_start;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        judge.note_pixel(pix, frame_start);
        pixels_sent++;
    endtask

    // apb write: setup then access
    task automatic write_reg(t_reg_idx idx, logic [DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        judge.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop the pixel stream and let every due result and the pipeline drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (judge.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        settings_cnt++;
    endtask

    // 3x3 frame with chosen cross around centre (1,1), the corners random
    task automatic send_frame3(t_pixel north, t_pixel west, t_pixel east, t_pixel south,
                               bit frame_start);
        send_pixel(t_pixel'($urandom_range(0, 255)), frame_start);
        send_pixel(north, 1'b0);
        send_pixel(t_pixel'($urandom_range(0, 255)), 1'b0);
        send_pixel(west, 1'b0);
        send_pixel(t_pixel'($urandom_range(0, 255)), 1'b0);
        send_pixel(east, 1'b0);
        send_pixel(t_pixel'($urandom_range(0, 255)), 1'b0);
        send_pixel(south, 1'b0);
        send_pixel(t_pixel'($urandom_range(0, 255)), 1'b0);
    endtask

    // new register values for one phase
    task automatic pick_settings();
        int unsigned v;
        if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
                0:       v = 0;
                1:       v = 511;
                2:       v = 510;
                3:       v = $urandom_range(0, 60);
                default: v = $urandom_range(0, 511);
            endcase
            write_reg(REG_THRESHOLD, with_junk(v, THR_BITS));
        end
        if ($urandom_range(0, 4) != 0) begin
            case ($urandom_range(0, 9))
                0:       v = $urandom_range(0, 2);
                1:       v = $urandom_range(11, 40);
                default: v = $urandom_range(3, 10);
            endcase
            write_reg(REG_LINE_WIDTH, with_junk(v, LW_BITS));
        end
        if ($urandom_range(0, 4) != 0) begin
            case ($urandom_range(0, 9))
                0:       v = $urandom_range(0, 2);
                1:       v = $urandom_range(8, 20);
                default: v = $urandom_range(3, 7);
            endcase
            write_reg(REG_FRAME_HEIGHT, with_junk(v, FH_BITS));
        end
        if ($urandom_range(0, 99) < 15) begin
            write_reg(REG_UNMAPPED, $urandom);
        end
    endtask

    // a run of pixels, mostly whole frames with random content
    task automatic run_phase(int n, bit fresh, bit boundary_starts, int noise_pct);
        int flen;
        bit fs;
        flen = judge.eff_width() * judge.eff_height();
        sender_quiet = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++) begin
            fs = (i == 0) ? fresh : (boundary_starts && (i % flen == 0));
            if ($urandom_range(0, 99) < noise_pct) fs = 1'b1;
            // restart instead of judging from line data that was never stored
            if (!fs && judge.centre_unwritten()) fs = 1'b1;
            send_pixel(pick_pixel(), fs);
        end
    endtask

    initial begin : stimulus
        int random_done;
        int phase;
        int flen;
        int n;
        random_done = 0;
        phase       = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // smallest frame from saturated sizes, widest gradient against zero threshold
        write_reg(REG_THRESHOLD, 0);
        write_reg(REG_LINE_WIDTH, 0);
        write_reg(REG_FRAME_HEIGHT, 1);
        send_frame3(8'd0, 8'd0, 8'd255, 8'd255, 1'b1);
        // next frame by wrap alone, flat cross equal to threshold
        send_frame3(8'd200, 8'd200, 8'd200, 8'd200, 1'b0);
        wait_idle();

        // a threshold equal to the widest gradient is not exceeded by it
        write_reg(REG_THRESHOLD, 510);
        write_reg(REG_LINE_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 3);
        send_frame3(8'd255, 8'd255, 8'd0, 8'd0, 1'b1);
        wait_idle();

        // random phases, a few of them at the largest sizes
        while (random_done < RANDOM_PIXELS) begin
            phase++;
            if (phase == 3) begin
                write_reg(REG_THRESHOLD, $urandom_range(0, 511));
                write_reg(REG_LINE_WIDTH, LINE_MAX);
                write_reg(REG_FRAME_HEIGHT, 3);
                n = 400;
                run_phase(n, 1'b1, 1'b0, 0);
            end else if (phase == 6) begin
                write_reg(REG_LINE_WIDTH, 3);
                write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
                n = 150;
                run_phase(n, 1'b1, 1'b0, 0);
            end else if (phase == 9) begin
                write_reg(REG_LINE_WIDTH, 11'h7FF);
                write_reg(REG_FRAME_HEIGHT, int'(MAX_HEIGHT));
                n = 100;
                run_phase(n, 1'b1, 1'b0, 0);
            end else begin
                pick_settings();
                flen = judge.eff_width() * judge.eff_height();
                if (flen > 400) begin
                    n = $urandom_range(100, 400);
                end else begin
                    n = flen * $urandom_range(1, 3);
                    if ($urandom_range(0, 4) == 0) n += $urandom_range(0, flen - 1);
                end
                // stay within the pixel budget
                if (n > RANDOM_PIXELS - random_done) n = RANDOM_PIXELS - random_done;
                run_phase(n, $urandom_range(0, 9) < 7, $urandom_range(0, 1),
                          ($urandom_range(0, 9) < 3) ? 3 : 0);
            end
            random_done += n;
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d pixel transactions over %0d register settings", pixels_sent,
                 settings_cnt);
        $display("checked %0d judged centres, %0d mismatches", judge.checked, judge.mismatches);
        if (judge.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/cget_pkg.sv
src/cget_line_store.sv
src/cross_gradient_edge_threshold_unit.sv
verif/cross_gradient_edge_threshold_unit_test.sv
